[hdl/gst_pkg.sv]
// Shared constants and types of the GPS sentence time extractor.
// Used by gst_parser and by the top level gps_sentence_time_extractor.
package gst_pkg;

  // Field text bytes kept per RMC sentence
  localparam int BUFFER_DEPTH = 16;
  // Fill count width: holds 0..BUFFER_DEPTH
  localparam int CNT_W = $clog2(BUFFER_DEPTH + 1);

  // Time-zone offset after reset, in hours
  localparam logic [3:0] ZONE_RESET = 4'd5;

  // One report, as emitted on the comma that closes the RMC status field
  typedef struct packed {
    logic       hour_tens;
    logic [3:0] hour_ones;
    logic [3:0] minute_tens;
    logic [3:0] minute_ones;
    logic       fix_valid;
    logic       fix_locked;
    logic       time_changed;
  } result_t;

endpackage

[hdl/gst_parser.sv]
// Byte-wise NMEA header matcher, RMC field capture, GSA lock tracking and
// time formatting. Produces one result per finished RMC time/status field.
// Depends on gst_pkg.
module gst_parser (
  input  logic             clk,
  input  logic             rst,
  input  logic             accept,
  input  logic [7:0]       rx_byte,
  input  logic [3:0]       zone_offset,
  output logic             res_fire,
  output gst_pkg::result_t res
);
  import gst_pkg::*;

  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_TWO    = 8'h32;
  localparam logic [7:0] CH_THREE  = 8'h33;
  localparam logic [7:0] CH_A      = 8'h41;
  localparam logic [7:0] CH_C      = 8'h43;
  localparam logic [7:0] CH_G      = 8'h47;
  localparam logic [7:0] CH_M      = 8'h4D;
  localparam logic [7:0] CH_P      = 8'h50;
  localparam logic [7:0] CH_R      = 8'h52;
  localparam logic [7:0] CH_S      = 8'h53;

  localparam logic [CNT_W-1:0] CNT_FULL  = CNT_W'(BUFFER_DEPTH);
  localparam logic [CNT_W-1:0] CNT_SHORT = CNT_W'(7);
  localparam logic [CNT_W-1:0] CNT_DIGITS = CNT_W'(4);

  typedef enum logic [3:0] {
    PH_IDLE, PH_DOLLAR, PH_G, PH_P, PH_R_OR_G, PH_M, PH_C, PH_COMMA,
    PH_FIELD, PH_SKIP, PH_GSA_S, PH_GSA_A, PH_GSA_C1, PH_GSA_MODE,
    PH_GSA_C2, PH_GSA_FIX
  } phase_t;

  phase_t           phase;
  logic [7:0]       time_chars [4];
  logic [CNT_W-1:0] stored_count;
  logic             comma_seen;
  logic             after_comma_pending;
  logic             status_is_a;
  logic             locked_flag;
  logic [12:0]      last_packed_time;

  logic             store;
  logic             finish;
  logic [7:0]       hour_raw;
  logic [7:0]       hour_fold;
  logic [9:0]       hour_adj;
  logic [9:0]       hour_less;
  logic             tens_calc;
  logic [3:0]       ones_calc;
  logic [12:0]      packed_time;

  // Report trigger: second comma inside the RMC field text
  assign finish   = accept && (phase == PH_FIELD) && comma_seen && (rx_byte == CH_COMMA);
  assign store    = stored_count < CNT_FULL;
  assign res_fire = finish;

  // Fold hour to twelve-hour form and subtract the zone offset
  always_comb begin
    hour_raw  = {time_chars[0][3:0], 3'b000} + {3'b000, time_chars[0][3:0], 1'b0}
              + {4'd0, time_chars[1][3:0]};
    hour_fold = (hour_raw > 8'd12) ? hour_raw - 8'd12 : hour_raw;
    hour_adj  = {2'b00, hour_fold} - {6'd0, zone_offset};
    if (hour_fold <= {4'd0, zone_offset}) begin
      hour_adj = hour_adj + 10'd12;
    end
    // A wrapped (negative) value counts as above nine
    tens_calc = hour_adj[9] || (hour_adj > 10'd9);
    hour_less = hour_adj - 10'd10;
    ones_calc = tens_calc ? hour_less[3:0] : hour_adj[3:0];
  end

  // Assemble the report; short field reads as 1999
  always_comb begin
    if (stored_count > CNT_SHORT) begin
      res.hour_tens   = tens_calc;
      res.hour_ones   = ones_calc;
      res.minute_tens = time_chars[2][3:0];
      res.minute_ones = time_chars[3][3:0];
    end else begin
      res.hour_tens   = 1'b1;
      res.hour_ones   = 4'd9;
      res.minute_tens = 4'd9;
      res.minute_ones = 4'd9;
    end
    packed_time      = {res.hour_tens, res.hour_ones, res.minute_tens, res.minute_ones};
    res.fix_valid    = status_is_a;
    res.fix_locked   = locked_flag;
    res.time_changed = packed_time != last_packed_time;
  end

  // Advance the header matcher and field capture on each accepted byte
  always_ff @(posedge clk) begin
    if (rst) begin
      phase               <= PH_IDLE;
      time_chars          <= '{default: 8'h00};
      stored_count        <= '0;
      comma_seen          <= 1'b0;
      after_comma_pending <= 1'b0;
      status_is_a         <= 1'b0;
      locked_flag         <= 1'b0;
      last_packed_time    <= '0;
    end else if (accept) begin
      unique case (phase)
        PH_IDLE:     phase <= (rx_byte == CH_LF) ? PH_DOLLAR : PH_IDLE;
        PH_DOLLAR:   phase <= (rx_byte == CH_DOLLAR) ? PH_G : PH_IDLE;
        PH_G:        phase <= (rx_byte == CH_G) ? PH_P : PH_IDLE;
        PH_P:        phase <= (rx_byte == CH_P) ? PH_R_OR_G : PH_IDLE;
        PH_R_OR_G: begin
          priority if (rx_byte == CH_R) phase <= PH_M;
          else if (rx_byte == CH_G)     phase <= PH_GSA_S;
          else                          phase <= PH_IDLE;
        end
        PH_M:        phase <= (rx_byte == CH_M) ? PH_C : PH_IDLE;
        PH_C:        phase <= (rx_byte == CH_C) ? PH_COMMA : PH_IDLE;
        PH_COMMA: begin
          stored_count        <= '0;
          comma_seen          <= 1'b0;
          after_comma_pending <= 1'b0;
          status_is_a         <= 1'b0;
          phase               <= (rx_byte == CH_COMMA) ? PH_FIELD : PH_IDLE;
        end
        PH_FIELD: begin
          if (finish) begin
            last_packed_time <= packed_time;
            stored_count     <= '0;
            phase            <= PH_SKIP;
          end else begin
            if (store) begin
              if (stored_count < CNT_DIGITS) begin
                time_chars[stored_count[1:0]] <= rx_byte;
              end
              if (after_comma_pending) begin
                status_is_a         <= rx_byte == CH_A;
                after_comma_pending <= 1'b0;
              end
              stored_count <= stored_count + 1'b1;
            end
            // Status byte is watched only if the comma itself was kept
            if (rx_byte == CH_COMMA) begin
              comma_seen          <= 1'b1;
              after_comma_pending <= store;
            end
          end
        end
        PH_SKIP:     phase <= PH_IDLE;
        PH_GSA_S:    phase <= (rx_byte == CH_S) ? PH_GSA_A : PH_IDLE;
        PH_GSA_A:    phase <= (rx_byte == CH_A) ? PH_GSA_C1 : PH_IDLE;
        PH_GSA_C1:   phase <= (rx_byte == CH_COMMA) ? PH_GSA_MODE : PH_IDLE;
        PH_GSA_MODE: phase <= (rx_byte == CH_A) ? PH_GSA_C2 : PH_IDLE;
        PH_GSA_C2:   phase <= (rx_byte == CH_COMMA) ? PH_GSA_FIX : PH_IDLE;
        PH_GSA_FIX: begin
          locked_flag <= (rx_byte == CH_TWO) || (rx_byte == CH_THREE);
          phase       <= PH_IDLE;
        end
        default:     phase <= PH_IDLE;
      endcase
    end
  end

endmodule

[hdl/gps_sentence_time_extractor.sv]
// A finished result is registered in the result register, or in the skid when stalled.
// Throughput: one byte per cycle while in_stall is low; a two-entry output queue
// (result register plus skid register) raises in_stall only when both entries hold
// unconsumed results. Reset: parser idle, all captured text and flags cleared, last
// time zero, zone offset 5 hours. Depends on gst_pkg and gst_parser.
module gps_sentence_time_extractor (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_wr_en,
  input  logic [3:0] cfg_wr_data,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] rx_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       hour_tens,
  output logic [3:0] hour_ones,
  output logic [3:0] minute_tens,
  output logic [3:0] minute_ones,
  output logic       fix_valid,
  output logic       fix_locked,
  output logic       time_changed
);
  import gst_pkg::*;

  logic [3:0] zone_offset_hours;
  logic       in_take;
  logic       out_take;
  logic       res_fire;
  result_t    res;
  result_t    out_data;
  result_t    skid_data;
  logic       skid_valid;

  assign in_stall = skid_valid;
  assign in_take  = in_valid && !in_stall;
  assign out_take = out_valid && !out_stall;

  // Hold the zone offset register
  always_ff @(posedge clk) begin
    if (rst) begin
      zone_offset_hours <= ZONE_RESET;
    end else if (cfg_wr_en) begin
      zone_offset_hours <= cfg_wr_data;
    end
  end

  gst_parser u_parser (
    .clk         (clk),
    .rst         (rst),
    .accept      (in_take),
    .rx_byte     (rx_byte),
    .zone_offset (zone_offset_hours),
    .res_fire    (res_fire),
    .res         (res)
  );

  // Output queue: result register with a skid register behind it
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (out_take) begin
        out_data   <= skid_data;
        skid_valid <= 1'b0;
      end
    end else if (res_fire) begin
      if (!out_valid || out_take) begin
        out_data  <= res;
        out_valid <= 1'b1;
      end else begin
        skid_data  <= res;
        skid_valid <= 1'b1;
      end
    end else if (out_take) begin
      out_valid <= 1'b0;
    end
  end

  assign hour_tens    = out_data.hour_tens;
  assign hour_ones    = out_data.hour_ones;
  assign minute_tens  = out_data.minute_tens;
  assign minute_ones  = out_data.minute_ones;
  assign fix_valid    = out_data.fix_valid;
  assign fix_locked   = out_data.fix_locked;
  assign time_changed = out_data.time_changed;

  // Skid entry is only ever filled behind a held result
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid register holds a result with result register empty");

  // A result arriving against a stalled full result register lands in the skid
  a_skid_fill: assert property (@(posedge clk) disable iff (rst)
    (res_fire && out_valid && out_stall && !skid_valid) |=> skid_valid)
    else $error("result lost while output stalled");

  // Draining the result register empties the skid and keeps the output valid
  a_skid_drain: assert property (@(posedge clk) disable iff (rst)
    (skid_valid && !out_stall) |=> (!skid_valid && out_valid))
    else $error("skid result not moved to output");

endmodule
